>>> rtl/kbc_pkg.sv
// Shared types and codes of the keyboard controller core.
`default_nettype none
package kbc_pkg;

   // Request kinds
   localparam logic [1:0] REQ_HOST  = 2'd0;
   localparam logic [1:0] REQ_KBD   = 2'd1;
   localparam logic [1:0] REQ_AUX   = 2'd2;
   localparam logic [1:0] REQ_SPARE = 2'd3;

   // Device port targets
   localparam logic [1:0] TGT_NONE = 2'd0;
   localparam logic [1:0] TGT_KBD  = 2'd1;
   localparam logic [1:0] TGT_AUX  = 2'd2;

   // Pending argument codes
   localparam logic [2:0] PEND_IDLE    = 3'd0;
   localparam logic [2:0] PEND_CTRL    = 3'd1;
   localparam logic [2:0] PEND_OUTPORT = 3'd2;
   localparam logic [2:0] PEND_KBDBUF  = 3'd3;
   localparam logic [2:0] PEND_AUXBUF  = 3'd4;
   localparam logic [2:0] PEND_AUXDEV  = 3'd5;
   localparam logic [2:0] PEND_RAM     = 3'd6;

   // Controller commands
   localparam logic [7:0] CMD_AUX_DISABLE = 8'hA7;
   localparam logic [7:0] CMD_AUX_ENABLE  = 8'hA8;
   localparam logic [7:0] CMD_TEST_AUX    = 8'hA9;
   localparam logic [7:0] CMD_CTRL_CHECK  = 8'hAA;
   localparam logic [7:0] CMD_TEST_KBD    = 8'hAB;
   localparam logic [7:0] CMD_KBD_DISABLE = 8'hAD;
   localparam logic [7:0] CMD_KBD_ENABLE  = 8'hAE;
   localparam logic [7:0] CMD_READ_INPORT = 8'hC0;
   localparam logic [7:0] CMD_READ_OUTPORT = 8'hD0;
   localparam logic [7:0] CMD_WRITE_OUTPORT = 8'hD1;
   localparam logic [7:0] CMD_WRITE_KBDBUF = 8'hD2;
   localparam logic [7:0] CMD_WRITE_AUXBUF = 8'hD3;
   localparam logic [7:0] CMD_WRITE_AUXDEV = 8'hD4;
   localparam logic [7:0] CMD_SYSTEM_RESET = 8'hFE;

   // Upper three bits of RAM read and write commands
   localparam logic [2:0] PAGE_RAM_READ  = 3'b001;
   localparam logic [2:0] PAGE_RAM_WRITE = 3'b011;

   // Fixed answers
   localparam logic [7:0] ANSWER_ZERO      = 8'h00;
   localparam logic [7:0] ANSWER_SELF_TEST = 8'h55;
   localparam logic [7:0] ANSWER_OUTPORT   = 8'hCF;

   // Command byte layout
   localparam logic [7:0] CTRL_RESET = 8'h44;
   localparam int unsigned KDIS_BIT = 4;
   localparam int unsigned ADIS_BIT = 5;

   localparam logic [4:0] RAM_ADDR_CTRL = 5'd0;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_byte;
      logic       cmd_port;
   } req_item_type;

   typedef struct packed {
      logic       host_valid;
      logic [7:0] host_byte;
      logic       host_from_aux;
      logic [1:0] port_target;
      logic [7:0] port_byte;
      logic [1:0] inhibit_update;
      logic       kbd_inhibit;
      logic       aux_inhibit;
      logic       reset_request;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] ctrl_byte;
      logic [2:0] pending_arg;
      logic [4:0] ram_index;
   } state_view_type;

   typedef struct packed {
      logic [7:0] ctrl_byte;
      logic [2:0] pending_arg;
      logic [4:0] ram_index;
      logic       ram_we;
      logic [4:0] ram_addr;
      logic [7:0] ram_wdata;
   } state_update_type;

endpackage
`default_nettype wire

>>> rtl/kbc_state.sv
// Controller state: command byte, pending argument, RAM address and internal RAM.
`default_nettype none
module kbc_state
   import kbc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             commit,
   input  wire state_update_type upd,
   input  wire logic [4:0]       rd_addr,
   output state_view_type        view,
   output logic [7:0]            rd_data
);

   logic [7:0] ctrl_ff, ctrl_in;
   logic [2:0] pend_ff, pend_in;
   logic [4:0] index_ff, index_in;
   logic [7:0] ram_ff [1:31];

   always_comb begin
      ctrl_in  = commit ? upd.ctrl_byte : ctrl_ff;
      pend_in  = commit ? upd.pending_arg : pend_ff;
      index_in = commit ? upd.ram_index : index_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff  <= CTRL_RESET;
         pend_ff  <= PEND_IDLE;
         index_ff <= 5'd0;
      end else begin
         ctrl_ff  <= ctrl_in;
         pend_ff  <= pend_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 31; i++) begin
            ram_ff[i] <= 8'h00;
         end
      end else if (commit && upd.ram_we && upd.ram_addr != RAM_ADDR_CTRL) begin
         ram_ff[upd.ram_addr] <= upd.ram_wdata;
      end
   end

   // Address zero aliases the command byte
   always_comb begin
      if (rd_addr == RAM_ADDR_CTRL) begin
         rd_data = ctrl_ff;
      end else begin
         rd_data = ram_ff[rd_addr];
      end
   end

   assign view.ctrl_byte   = ctrl_ff;
   assign view.pending_arg = pend_ff;
   assign view.ram_index   = index_ff;

endmodule
`default_nettype wire

>>> rtl/kbc_decode.sv
// Per-item decode: result fields and next controller state.
`default_nettype none
module kbc_decode
   import kbc_pkg::*;
(
   input  wire req_item_type   item,
   input  wire state_view_type st,
   input  wire logic [7:0]     rd_data,
   output logic [4:0]          rd_addr,
   output rsp_item_type        rsp,
   output state_update_type    upd
);

   logic [7:0] d;

   assign d       = item.data_byte;
   assign rd_addr = d[4:0];

   always_comb begin
      rsp             = '0;
      upd.ctrl_byte   = st.ctrl_byte;
      upd.pending_arg = st.pending_arg;
      upd.ram_index   = st.ram_index;
      upd.ram_we      = 1'b0;
      upd.ram_addr    = st.ram_index;
      upd.ram_wdata   = d;

      case (item.req_type)
         REQ_HOST: begin
            if (st.pending_arg != PEND_IDLE) begin
               // Any host write completes the pending command
               upd.pending_arg = PEND_IDLE;
               case (st.pending_arg)
                  PEND_CTRL: begin
                     upd.ctrl_byte      = d;
                     rsp.inhibit_update = 2'b11;
                     rsp.kbd_inhibit    = d[KDIS_BIT];
                     rsp.aux_inhibit    = d[ADIS_BIT];
                  end
                  PEND_OUTPORT: begin
                  end
                  PEND_KBDBUF: begin
                     rsp.host_valid = 1'b1;
                     rsp.host_byte  = d;
                  end
                  PEND_AUXBUF: begin
                     rsp.host_valid    = 1'b1;
                     rsp.host_byte     = d;
                     rsp.host_from_aux = 1'b1;
                  end
                  PEND_AUXDEV: begin
                     rsp.port_target = TGT_AUX;
                     rsp.port_byte   = d;
                  end
                  PEND_RAM: begin
                     if (st.ram_index == RAM_ADDR_CTRL) begin
                        upd.ctrl_byte = d;
                     end else begin
                        upd.ram_we = 1'b1;
                     end
                  end
                  default: begin
                     rsp.port_target = TGT_KBD;
                     rsp.port_byte   = d;
                  end
               endcase
            end else if (item.cmd_port) begin
               case (d)
                  CMD_AUX_DISABLE: begin
                     upd.ctrl_byte[ADIS_BIT] = 1'b1;
                     rsp.inhibit_update[1]   = 1'b1;
                     rsp.aux_inhibit         = 1'b1;
                  end
                  CMD_AUX_ENABLE: begin
                     upd.ctrl_byte[ADIS_BIT] = 1'b0;
                     rsp.inhibit_update[1]   = 1'b1;
                  end
                  CMD_KBD_DISABLE: begin
                     upd.ctrl_byte[KDIS_BIT] = 1'b1;
                     rsp.inhibit_update[0]   = 1'b1;
                     rsp.kbd_inhibit         = 1'b1;
                  end
                  CMD_KBD_ENABLE: begin
                     upd.ctrl_byte[KDIS_BIT] = 1'b0;
                     rsp.inhibit_update[0]   = 1'b1;
                  end
                  CMD_TEST_AUX, CMD_TEST_KBD, CMD_READ_INPORT: begin
                     rsp.host_valid = 1'b1;
                     rsp.host_byte  = ANSWER_ZERO;
                  end
                  CMD_CTRL_CHECK: begin
                     rsp.host_valid = 1'b1;
                     rsp.host_byte  = ANSWER_SELF_TEST;
                  end
                  CMD_READ_OUTPORT: begin
                     rsp.host_valid = 1'b1;
                     rsp.host_byte  = ANSWER_OUTPORT;
                  end
                  CMD_WRITE_OUTPORT: upd.pending_arg = PEND_OUTPORT;
                  CMD_WRITE_KBDBUF:  upd.pending_arg = PEND_KBDBUF;
                  CMD_WRITE_AUXBUF:  upd.pending_arg = PEND_AUXBUF;
                  CMD_WRITE_AUXDEV:  upd.pending_arg = PEND_AUXDEV;
                  CMD_SYSTEM_RESET:  rsp.reset_request = 1'b1;
                  default: begin
                     if (d[7:5] == PAGE_RAM_READ) begin
                        rsp.host_valid = 1'b1;
                        rsp.host_byte  = rd_data;
                     end else if (d[7:5] == PAGE_RAM_WRITE) begin
                        if (d[4:0] == RAM_ADDR_CTRL) begin
                           upd.pending_arg = PEND_CTRL;
                        end else begin
                           upd.ram_index   = d[4:0];
                           upd.pending_arg = PEND_RAM;
                        end
                     end
                  end
               endcase
            end else begin
               rsp.port_target = TGT_KBD;
               rsp.port_byte   = d;
            end
         end
         REQ_KBD: begin
            rsp.host_valid = 1'b1;
            rsp.host_byte  = d;
         end
         REQ_AUX: begin
            rsp.host_valid    = 1'b1;
            rsp.host_byte     = d;
            rsp.host_from_aux = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/ps2_keyboard_controller_core_top.sv
// Top level of the keyboard controller core: input register, decode, result register.
// Each accepted item (host write, keyboard byte, auxiliary byte or spare request) yields
// exactly one result item: it is held in the input register, where the decode reads the
// controller state, and then moves into the result register. The result register lets
// the next item enter while a finished result waits, so the rate is one item per cycle
// as long as the result side keeps up. The controller state (command byte, pending
// argument, RAM address and 31 RAM bytes) lives in flip-flops that the synchronous reset
// sets (command byte to 0x44, the rest to zero), so the block is ready right after reset.
`default_nettype none
module ps2_keyboard_controller_core_top
   import kbc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_req_type,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_cmd_port,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_host_valid,
   output logic [7:0]      rsp_host_byte,
   output logic            rsp_host_from_aux,
   output logic [1:0]      rsp_port_target,
   output logic [7:0]      rsp_port_byte,
   output logic [1:0]      rsp_inhibit_update,
   output logic            rsp_kbd_inhibit,
   output logic            rsp_aux_inhibit,
   output logic            rsp_reset_request
);

   req_item_type     in_ff, in_in;
   logic             in_valid_ff, in_valid_in;
   rsp_item_type     out_ff, out_in;
   logic             out_valid_ff, out_valid_in;
   state_view_type   st;
   state_update_type upd;
   logic [4:0]       rd_addr;
   logic [7:0]       rd_data;
   logic             advance;
   logic             req_xfer;

   // Move the held item into the result register when that slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_in.req_type   = req_req_type;
      in_in.data_byte  = req_data_byte;
      in_in.cmd_port   = req_cmd_port;
      in_valid_in      = req_xfer || (in_valid_ff && !advance);
      out_valid_in     = advance || (out_valid_ff && !rsp_ready);
   end

   kbc_state u_state (
      .clock   (clock),
      .reset   (reset),
      .commit  (advance),
      .upd     (upd),
      .rd_addr (rd_addr),
      .view    (st),
      .rd_data (rd_data)
   );

   kbc_decode u_decode (
      .item    (in_ff),
      .st      (st),
      .rd_data (rd_data),
      .rd_addr (rd_addr),
      .rsp     (out_in),
      .upd     (upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ff <= in_in;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_host_valid     = out_ff.host_valid;
   assign rsp_host_byte      = out_ff.host_byte;
   assign rsp_host_from_aux  = out_ff.host_from_aux;
   assign rsp_port_target    = out_ff.port_target;
   assign rsp_port_byte      = out_ff.port_byte;
   assign rsp_inhibit_update = out_ff.inhibit_update;
   assign rsp_kbd_inhibit    = out_ff.kbd_inhibit;
   assign rsp_aux_inhibit    = out_ff.aux_inhibit;
   assign rsp_reset_request  = out_ff.reset_request;

   // Hold the input item while the result register is blocked
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("input item lost while stalled");

   // Stall only when both registers are full and the result is not taken
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("input stalled without cause");

   // A host write with an argument pending always clears the pending state
   a_pend_clear: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.req_type == REQ_HOST && st.pending_arg != PEND_IDLE
      |=> st.pending_arg == PEND_IDLE)
      else $error("pending argument not consumed");

   // Received device bytes leave the controller state untouched
   a_rx_no_state: assert property (@(posedge clock) disable iff (reset)
      advance && (in_ff.req_type == REQ_KBD || in_ff.req_type == REQ_AUX)
      |=> $stable(st))
      else $error("received byte changed controller state");

   // Host byte and source flag stay zero while host_valid is low
   a_host_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_host_valid |-> rsp_host_byte == 8'h00 && !rsp_host_from_aux)
      else $error("host byte set without host_valid");

endmodule
`default_nettype wire
